### rtl/core/cpct_pkg.sv
// ----------------------------------------------------------------------------
// Collider pair contact tracker package
// Shared types and constants: the input and result words, the hand-off from
// the overlap engine to the contact bitmap, and the event codes.
// ----------------------------------------------------------------------------
package cpct_pkg;

  localparam int ID_W        = 5;
  localparam int ID_RANGE    = 2 ** ID_W;
  localparam int MAX_IDS_DEF = 32;

  localparam int COORD_W = 16;
  localparam int AXIS_W  = 20;
  localparam int MAG_W   = 18;
  localparam int PROD_W  = 2 * MAG_W;
  localparam int ACC_W   = PROD_W + 1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ENTER = 2'd1;
  localparam logic [1:0] EV_STAY  = 2'd2;
  localparam logic [1:0] EV_EXIT  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]           first_id;
    logic [ID_W-1:0]           second_id;
    logic                      first_kind;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic [COORD_W-1:0]        first_w;
    logic [COORD_W-1:0]        first_h;
    logic                      second_kind;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [COORD_W-1:0]        second_w;
    logic [COORD_W-1:0]        second_h;
  } item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic       overlapping;
  } result_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } fin_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             overlap;
  } axis_t;

endpackage

### rtl/core/collider_pair_contact_tracker.sv
// ----------------------------------------------------------------------------
// Collider pair contact tracker
// Tests one collider pair per word (rectangle or circle on each side) and
// reports none, enter, stay or exit against a per-pair contact bitmap.
// ----------------------------------------------------------------------------
// Usage:
// A word on item is taken at a rising edge where start is high and busy is
// low. busy then stays high while the overlap engine runs: two passes of
// the axis distance unit, then three passes of the shared 18 by 18
// squaring multiplier (x distance, y distance, radius sum).
// The result word appears on result for exactly one cycle, marked by done,
// registered from the last squaring pass. A new word can be taken in
// that same cycle, but not while busy is high, so words do not overlap.
// The receiver cannot stall, so done is never held.
// Reset clears the sequencer and the valid bit of every bitmap row, so all
// pairs start with no contact; no clearing pass is needed and the block can
// take a word in the first cycle after reset.
// ----------------------------------------------------------------------------
module collider_pair_contact_tracker import cpct_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  fin_t fin;
  logic accept;

  assign accept = start && !busy;

  cpct_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .fin   (fin)
  );

  cpct_flags #(
    .MAX_IDS (MAX_IDS)
  ) u_flags (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .first_id  (item.first_id),
    .second_id (item.second_id),
    .fin       (fin),
    .done      (done),
    .result    (result)
  );

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("Result strobe without a word in flight.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Result strobe while the engine is still busy.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Engine did not start on an accepted word.");

  a_event_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.overlapping ==
              ((result.event_code == EV_ENTER) || (result.event_code == EV_STAY))))
    else $error("Event code disagrees with the overlap flag.");
`endif

endmodule

### rtl/core/cpct_axis.sv
// ----------------------------------------------------------------------------
// Axis distance unit
// Works out the absolute center distance on one axis at doubled scale, or,
// for a circle against a rectangle, the distance from the circle center to
// the rectangle's clamped span. Also gives the strict rectangle overlap test.
// ----------------------------------------------------------------------------
module cpct_axis import cpct_pkg::*; (
  input  logic signed [COORD_W-1:0] pos_a,
  input  logic [COORD_W-1:0]        ext_a,
  input  logic signed [COORD_W-1:0] pos_b,
  input  logic [COORD_W-1:0]        ext_b,
  input  logic                      mixed,
  output axis_t                     res
);

  logic signed [AXIS_W-1:0] ca;
  logic signed [AXIS_W-1:0] lo;
  logic signed [AXIS_W-1:0] hi;
  logic signed [AXIS_W-1:0] cb;
  logic signed [AXIS_W-1:0] d;
  logic signed [AXIS_W-1:0] d_abs;

  always_comb begin
    ca = (AXIS_W'(pos_a) <<< 1) + signed'(AXIS_W'(ext_a));
    lo = AXIS_W'(pos_b) <<< 1;
    hi = lo + (signed'(AXIS_W'(ext_b)) <<< 1);
    cb = lo + signed'(AXIS_W'(ext_b));
    priority if (!mixed) begin
      d = ca - cb;
    end else if (ca < lo) begin
      d = ca - lo;
    end else if (ca > hi) begin
      d = ca - hi;
    end else begin
      d = '0;
    end
    d_abs = d[AXIS_W-1] ? -d : d;
    res.mag = d_abs[MAG_W-1:0];
    res.overlap = res.mag < (MAG_W'(ext_a) + MAG_W'(ext_b));
  end

endmodule

### rtl/core/cpct_engine.sv
// ----------------------------------------------------------------------------
// Overlap engine
// A small sequencer that runs the axis unit twice and one shared squaring
// multiplier three times to decide whether the two shapes of a word overlap.
// ----------------------------------------------------------------------------
module cpct_engine import cpct_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item,
  output logic  busy,
  output fin_t  fin
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_AX   = 3'd1;
  localparam logic [2:0] ST_AY   = 3'd2;
  localparam logic [2:0] ST_SQY  = 3'd3;
  localparam logic [2:0] ST_SQR  = 3'd4;

  logic [2:0]       state;
  item_t            cur;
  logic [MAG_W-1:0] mag;
  logic [ACC_W-1:0] acc;
  logic             rect_ok;

  logic                      swap;
  logic                      mixed;
  logic                      both_rect;
  logic                      s0_kind;
  logic                      s1_kind;
  logic signed [COORD_W-1:0] s0_x;
  logic signed [COORD_W-1:0] s0_y;
  logic [COORD_W-1:0]        s0_w;
  logic [COORD_W-1:0]        s0_h;
  logic signed [COORD_W-1:0] s1_x;
  logic signed [COORD_W-1:0] s1_y;
  logic [COORD_W-1:0]        s1_w;
  logic [COORD_W-1:0]        s1_h;
  logic signed [COORD_W-1:0] pos_a;
  logic [COORD_W-1:0]        ext_a;
  logic signed [COORD_W-1:0] pos_b;
  logic [COORD_W-1:0]        ext_b;
  logic [MAG_W-1:0]          radius;
  logic [PROD_W-1:0]         prod;
  axis_t                     axis_res;
  logic                      accept;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign swap      = !cur.first_kind && cur.second_kind;
  assign mixed     = cur.first_kind != cur.second_kind;
  assign both_rect = !cur.first_kind && !cur.second_kind;

  always_comb begin
    s0_kind = swap ? cur.second_kind : cur.first_kind;
    s0_x    = swap ? cur.second_x    : cur.first_x;
    s0_y    = swap ? cur.second_y    : cur.first_y;
    s0_w    = swap ? cur.second_w    : cur.first_w;
    s0_h    = swap ? cur.second_h    : cur.first_h;
    s1_kind = swap ? cur.first_kind  : cur.second_kind;
    s1_x    = swap ? cur.first_x     : cur.second_x;
    s1_y    = swap ? cur.first_y     : cur.second_y;
    s1_w    = swap ? cur.first_w     : cur.second_w;
    s1_h    = swap ? cur.first_h     : cur.second_h;
    if (state == ST_AY) begin
      pos_a = s0_y;
      ext_a = s0_kind ? s0_w : s0_h;
      pos_b = s1_y;
      ext_b = s1_kind ? s1_w : s1_h;
    end else begin
      pos_a = s0_x;
      ext_a = s0_w;
      pos_b = s1_x;
      ext_b = s1_w;
    end
    radius = mixed ? MAG_W'(s0_w) : MAG_W'(s0_w) + MAG_W'(s1_w);
  end

  cpct_axis u_axis (
    .pos_a (pos_a),
    .ext_a (ext_a),
    .pos_b (pos_b),
    .ext_b (ext_b),
    .mixed (mixed),
    .res   (axis_res)
  );

  assign prod = mag * mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= ST_AX;
        ST_AX:   state <= ST_AY;
        ST_AY:   state <= ST_SQY;
        ST_SQY:  state <= ST_SQR;
        ST_SQR:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    unique case (state)
      ST_AX: begin
        mag     <= axis_res.mag;
        rect_ok <= axis_res.overlap;
      end
      ST_AY: begin
        acc     <= ACC_W'(prod);
        mag     <= axis_res.mag;
        rect_ok <= rect_ok && axis_res.overlap;
      end
      ST_SQY: begin
        acc <= acc + ACC_W'(prod);
        mag <= radius;
      end
      default: begin
      end
    endcase
  end

  assign fin.valid = (state == ST_SQR);
  assign fin.hit   = both_rect ? rect_ok : (acc <= ACC_W'(prod));

endmodule

### rtl/core/cpct_flags.sv
// ----------------------------------------------------------------------------
// Contact bitmap
// One row of contact bits per first ID, held in a memory with a valid bit per
// row. The row is read when a word is taken and written back with the new
// contact bit once the overlap result is known; the event is derived here.
// ----------------------------------------------------------------------------
module cpct_flags import cpct_pkg::*; #(
  parameter int MAX_IDS = MAX_IDS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [ID_W-1:0] first_id,
  input  logic [ID_W-1:0] second_id,
  input  fin_t            fin,
  output logic            done,
  output result_t         result
);

  localparam int IDW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;

  logic [IDW-1:0]     id_map [ID_RANGE];
  logic [MAX_IDS-1:0] mem [MAX_IDS];
  logic [MAX_IDS-1:0] row_valid;
  logic [MAX_IDS-1:0] rdata;
  logic [IDW-1:0]     row_sel;
  logic [IDW-1:0]     col_sel;
  logic [MAX_IDS-1:0] cur_row;
  logic [MAX_IDS-1:0] new_row;
  logic               old_bit;
  logic [1:0]         ev;

  for (genvar g = 0; g < ID_RANGE; g++) begin : g_id_map
    assign id_map[g] = IDW'(g % MAX_IDS);
  end

  always_comb begin
    cur_row = row_valid[row_sel] ? rdata : '0;
    old_bit = cur_row[col_sel];
    new_row = cur_row;
    new_row[col_sel] = fin.hit;
    if (fin.hit) begin
      ev = old_bit ? EV_STAY : EV_ENTER;
    end else begin
      ev = old_bit ? EV_EXIT : EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata   <= mem[id_map[first_id]];
      row_sel <= id_map[first_id];
      col_sel <= id_map[second_id];
    end
    if (fin.valid) begin
      mem[row_sel]       <= new_row;
      result.event_code  <= ev;
      result.overlapping <= fin.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      done <= fin.valid;
      if (fin.valid) begin
        row_valid[row_sel] <= 1'b1;
      end
    end
  end

endmodule
